// File: rtl/cascaded_pd_joint_servo_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the joint servo unit
// Shared property wrappers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CASCADED_PD_JOINT_SERVO_UNIT_DEFINES_SVH
`define CASCADED_PD_JOINT_SERVO_UNIT_DEFINES_SVH

// Same-cycle implication.
`define CPJS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CPJS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cpjs_pkg.sv
// ----------------------------------------------------------------------------
// cpjs_pkg
// Types, constants and saturation helpers for the joint servo unit.
// ----------------------------------------------------------------------------
package cpjs_pkg;

  typedef enum logic [1:0] {
    KIND_STATIC = 2'd0,
    KIND_TRANS  = 2'd1,
    KIND_ROT    = 2'd2,
    KIND_BASE   = 2'd3
  } link_kind_e;

  typedef enum logic [2:0] {
    REG_LINK_KIND = 3'd0,
    REG_MIN_POS   = 3'd1,
    REG_MAX_POS   = 3'd2,
    REG_MAX_SPEED = 3'd3,
    REG_MAX_ACCEL = 3'd4,
    REG_TIME_STEP = 3'd5,
    REG_INV_STEP  = 3'd6
  } reg_index_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PERR, ST_PERR2, ST_PDER, ST_PKP, ST_PKD, ST_PSUM,
    ST_VERR, ST_VKP, ST_VKD, ST_VSUM, ST_ACL, ST_VINT, ST_PINT,
    ST_CHKHI, ST_FIXHI, ST_CHKLO, ST_FIXLO, ST_OUT, ST_WAIT_MUL, ST_WAIT_MOD
  } state_e;

  typedef struct packed {
    logic               start;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic signed [35:0] x;
  } mod_req_t;

  localparam logic signed [31:0] Q_PI        = 32'sd205887;
  localparam logic [18:0]        TWO_PI      = 19'd411775;
  localparam int                 MOD_BITS    = 37;
  // Whole number of turns that lifts any dividend above zero.
  localparam logic [36:0]        MOD_OFFSET  = 37'd34360153100;
  localparam logic signed [31:0] KP_POS      = 32'sd131072;
  localparam logic signed [31:0] KD_POS      = 32'sd13107;
  localparam logic signed [31:0] KP_VEL      = 32'sd327680;
  localparam logic signed [31:0] KD_VEL      = 32'sd32768;

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    if (v > 49'sd2147483647) return 32'sh7fffffff;
    if (v < -49'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] clampsym(input logic signed [48:0] v,
                                                  input logic [30:0] lim);
    logic signed [48:0] l;
    l = $signed({18'd0, lim});
    if (v > l) return l[31:0];
    if (v < -l) return 32'(-l);
    return v[31:0];
  endfunction

endpackage

// File: rtl/cpjs_mul.sv
// ----------------------------------------------------------------------------
// cpjs_mul
// Bit-serial signed Q16.16 multiplier: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module cpjs_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cpjs_pkg::mul_req_t req_i,
  output logic               done_o,
  output logic signed [31:0] res_o
);
  import cpjs_pkg::*;

  logic               busy_q, busy_d, done_q, done_d;
  logic [4:0]         cnt_q, cnt_d;
  logic signed [31:0] a_q, a_d, res_q, res_d;
  logic signed [32:0] hi_q, hi_d;
  logic [31:0]        lo_q, lo_d;
  logic signed [33:0] sum;
  logic signed [48:0] shifted;

  always_comb begin
    sum = 34'(hi_q);
    if (lo_q[0]) begin
      // The top multiplier bit carries negative weight.
      if (cnt_q == 5'd31) sum = 34'(hi_q) - 34'(a_q);
      else sum = 34'(hi_q) + 34'(a_q);
    end
    shifted = $signed({sum[33:1], sum[0], lo_q[31:17]});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    res_d  = res_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 5'd0;
      a_d    = req_i.a;
      hi_d   = '0;
      lo_d   = req_i.b;
    end else if (busy_q) begin
      hi_d  = sum[33:1];
      lo_d  = {sum[0], lo_q[31:1]};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = sat32(shifted);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: rtl/cpjs_mod.sv
// ----------------------------------------------------------------------------
// cpjs_mod
// Bit-serial floor remainder by one full turn, restoring, one bit a cycle.
// ----------------------------------------------------------------------------
module cpjs_mod (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cpjs_pkg::mod_req_t req_i,
  output logic               done_o,
  output logic [18:0]        rem_o
);
  import cpjs_pkg::*;

  logic                busy_q, busy_d, done_q, done_d;
  logic [5:0]          cnt_q, cnt_d;
  logic [MOD_BITS-1:0] dvd_q, dvd_d;
  logic [18:0]         rem_q, rem_d;
  logic [19:0]         trial;

  always_comb begin
    trial = {rem_q, dvd_q[MOD_BITS-1]};
    if (trial >= {1'b0, TWO_PI}) trial = trial - {1'b0, TWO_PI};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = $unsigned(MOD_BITS'(req_i.x)) + MOD_OFFSET;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = trial[18:0];
      dvd_d = {dvd_q[MOD_BITS-2:0], 1'b0};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(MOD_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/cascaded_pd_joint_servo_unit.sv
// ----------------------------------------------------------------------------
// cascaded_pd_joint_servo_unit
// Cascaded position/velocity PD servo for one joint, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage: one input word per servo tick on the in channel (operation,
// reference, feed-forward velocity), one result word per tick on the out
// channel (controller acceleration, new position, new velocity). Both
// channels move a word when valid is high and stall is low.
// Configuration is written through cfg_we_i/cfg_index_i/cfg_data_i while
// the unit is idle, a rule the user must keep, as the unit itself does not
// enforce it; unknown indexes are ignored. A tick is worked on by a
// sequencer around a shared bit-serial multiplier and a bit-serial turn
// remainder. A static link goes straight to the output step; a rotational
// tick runs up to three remainders. One tick is in flight at a time:
// in_stall_o stays high until the result is in the output register, and
// only then is a new word taken.
// Reset clears the joint state and error history and loads the default
// time step. If the receiver stalls, the result is held and the next
// tick waits in the sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module cascaded_pd_joint_servo_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic signed [31:0] reference_i,
  input  logic signed [31:0] feedforward_velocity_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] acceleration_o,
  output logic signed [31:0] position_out_o,
  output logic signed [31:0] velocity_out_o
);
  import cpjs_pkg::*;
  `include "cascaded_pd_joint_servo_unit_defines.svh"

  link_kind_e         kind_q;
  logic signed [31:0] min_q, max_q;
  logic [30:0]        speed_q, accel_q, inv_q;
  logic [16:0]        ts_q;

  state_e             state_q, state_d, ret_q, ret_d;
  logic signed [31:0] ref_q, ref_d, ff_q, ff_d, err_q, err_d, der_q, der_d;
  logic signed [31:0] t_q, t_d, vref_q, vref_d, acc_q, acc_d;
  logic signed [31:0] pos_q, pos_d, vel_q, vel_d, lpe_q, lpe_d, lve_q, lve_d;
  logic signed [33:0] p_q, p_d;
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] oacc_q, oacc_d, opos_q, opos_d, ovel_q, ovel_d;

  mul_req_t           mul_req;
  mod_req_t           mod_req;
  logic               mul_done, mod_done;
  logic signed [31:0] mul_res;
  logic [18:0]        mod_rem;
  logic               moving, out_free;
  logic signed [31:0] gkp_pos, gkd_pos, gkp_vel, gkd_vel, vnew;
  logic signed [33:0] rem_s;

  cpjs_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  cpjs_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= KIND_STATIC;
      min_q   <= '0;
      max_q   <= '0;
      speed_q <= '0;
      accel_q <= '0;
      ts_q    <= 17'd655;
      inv_q   <= 31'd6553600;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_LINK_KIND: kind_q  <= link_kind_e'(cfg_data_i[1:0]);
        REG_MIN_POS:   min_q   <= cfg_data_i;
        REG_MAX_POS:   max_q   <= cfg_data_i;
        REG_MAX_SPEED: speed_q <= cfg_data_i[30:0];
        REG_MAX_ACCEL: accel_q <= cfg_data_i[30:0];
        REG_TIME_STEP: ts_q    <= cfg_data_i[16:0];
        REG_INV_STEP:  inv_q   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  assign moving   = (kind_q == KIND_TRANS) || (kind_q == KIND_ROT);
  assign gkp_pos  = moving ? KP_POS : '0;
  assign gkd_pos  = moving ? KD_POS : '0;
  assign gkp_vel  = moving ? KP_VEL : '0;
  assign gkd_vel  = moving ? KD_VEL : '0;
  assign out_free = !out_valid_q || !out_stall_i;
  assign rem_s    = $signed({15'd0, mod_rem});
  assign vnew     = clampsym(49'(sat32(49'(vel_q) + 49'(mul_res))), speed_q);

  // Next state. Multiply and remainder steps park in a wait state and
  // return to the step recorded in ret_q.
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = (kind_q == KIND_STATIC) ? ST_OUT :
                                          (operation_i ? ST_VERR : ST_PERR);
      ST_PERR: begin
        if (kind_q == KIND_ROT) begin
          state_d = ST_WAIT_MOD;
          ret_d   = ST_PERR2;
        end else begin
          state_d = ST_PDER;
        end
      end
      ST_PERR2: state_d = ST_PDER;
      ST_PDER:  begin state_d = ST_WAIT_MUL; ret_d = ST_PKP; end
      ST_PKP:   begin state_d = ST_WAIT_MUL; ret_d = ST_PKD; end
      ST_PKD:   begin state_d = ST_WAIT_MUL; ret_d = ST_PSUM; end
      ST_PSUM:  state_d = ST_VERR;
      ST_VERR:  begin state_d = ST_WAIT_MUL; ret_d = ST_VKP; end
      ST_VKP:   begin state_d = ST_WAIT_MUL; ret_d = ST_VKD; end
      ST_VKD:   begin state_d = ST_WAIT_MUL; ret_d = ST_VSUM; end
      ST_VSUM:  state_d = moving ? ST_ACL : ST_OUT;
      ST_ACL:   begin state_d = ST_WAIT_MUL; ret_d = ST_VINT; end
      ST_VINT:  begin state_d = ST_WAIT_MUL; ret_d = ST_PINT; end
      ST_PINT:  state_d = ST_CHKHI;
      ST_CHKHI: begin
        if (kind_q == KIND_ROT && p_q > 34'(max_q)) begin
          state_d = ST_WAIT_MOD;
          ret_d   = ST_FIXHI;
        end else begin
          state_d = (kind_q == KIND_ROT) ? ST_CHKLO : ST_OUT;
        end
      end
      ST_FIXHI: state_d = ST_CHKLO;
      ST_CHKLO: begin
        if (p_q < 34'(min_q)) begin
          state_d = ST_WAIT_MOD;
          ret_d   = ST_FIXLO;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_FIXLO:    state_d = ST_OUT;
      ST_OUT:      if (out_free) state_d = ST_IDLE;
      ST_WAIT_MUL: if (mul_done) state_d = ret_q;
      ST_WAIT_MOD: if (mod_done) state_d = ret_q;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath and unit requests.
  always_comb begin
    ref_d = ref_q;   ff_d = ff_q;     err_d = err_q;
    der_d = der_q; t_d = t_q;       vref_d = vref_q; acc_d = acc_q;
    pos_d = pos_q; vel_d = vel_q;   lpe_d = lpe_q;   lve_d = lve_q;
    p_d = p_q;
    out_valid_d = out_valid_q && out_stall_i;
    oacc_d = oacc_q; opos_d = opos_q; ovel_d = ovel_q;
    mul_req = '0;
    mod_req = '0;
    unique case (state_q)
      ST_IDLE: begin
        ref_d = reference_i;
        ff_d  = feedforward_velocity_i;
        acc_d = '0;
        if (operation_i) vref_d = reference_i;
      end
      ST_PERR: begin
        mod_req.start = (kind_q == KIND_ROT);
        mod_req.x     = 36'(ref_q) - 36'(pos_q) + 36'(Q_PI);
        err_d         = sat32(49'(ref_q) - 49'(pos_q));
      end
      ST_PERR2: err_d = 32'(rem_s) - Q_PI;
      ST_PDER: begin
        mul_req = '{1'b1, sat32(49'(err_q) - 49'(lpe_q)), $signed({1'b0, inv_q})};
        lpe_d   = err_q;
      end
      ST_PKP: begin
        der_d   = mul_res;
        mul_req = '{1'b1, err_q, gkp_pos};
      end
      ST_PKD: begin
        t_d     = mul_res;
        mul_req = '{1'b1, der_q, gkd_pos};
      end
      ST_PSUM: vref_d = clampsym(49'(sat32(49'(t_q) + 49'(mul_res))) + 49'(ff_q), speed_q);
      ST_VERR: begin
        err_d   = sat32(49'(vref_q) - 49'(vel_q));
        mul_req = '{1'b1, sat32(49'(sat32(49'(vref_q) - 49'(vel_q))) - 49'(lve_q)),
                    $signed({1'b0, inv_q})};
        lve_d   = sat32(49'(vref_q) - 49'(vel_q));
      end
      ST_VKP: begin
        der_d   = mul_res;
        mul_req = '{1'b1, err_q, gkp_vel};
      end
      ST_VKD: begin
        t_d     = mul_res;
        mul_req = '{1'b1, der_q, gkd_vel};
      end
      ST_VSUM: acc_d = sat32(49'(t_q) + 49'(mul_res));
      ST_ACL:  mul_req = '{1'b1, clampsym(49'(acc_q), accel_q), $signed({15'd0, ts_q})};
      ST_VINT: begin
        vel_d   = vnew;
        mul_req = '{1'b1, vnew, $signed({15'd0, ts_q})};
      end
      ST_PINT: p_d = 34'(pos_q) + 34'(mul_res);
      ST_CHKHI: begin
        mod_req.x = 36'(max_q) - 36'(p_q);
        if (kind_q == KIND_ROT) begin
          mod_req.start = (p_q > 34'(max_q));
        end else begin
          // Translational: upper bound first, so an inverted range ends at min.
          if (p_q > 34'(max_q)) pos_d = max_q;
          else pos_d = p_q[31:0];
          if (p_q < 34'(min_q) || (p_q > 34'(max_q) && max_q < min_q)) pos_d = min_q;
        end
      end
      ST_FIXHI: p_d = 34'(max_q) - rem_s;
      ST_CHKLO: begin
        mod_req.x     = 36'(p_q) - 36'(min_q);
        mod_req.start = (p_q < 34'(min_q));
        pos_d         = sat32(49'(p_q));
      end
      ST_FIXLO: pos_d = sat32(49'(min_q) + 49'(rem_s));
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          oacc_d      = acc_q;
          opos_d      = pos_q;
          ovel_d      = vel_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      vel_q       <= '0;
      lpe_q       <= '0;
      lve_q       <= '0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      vel_q       <= vel_d;
      lpe_q       <= lpe_d;
      lve_q       <= lve_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ref_q <= ref_d; ff_q   <= ff_d;   err_q <= err_d;
    der_q  <= der_d;  t_q   <= t_d;   vref_q <= vref_d; acc_q <= acc_d;
    p_q    <= p_d;
    oacc_q <= oacc_d; opos_q <= opos_d; ovel_q <= ovel_d;
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign acceleration_o = oacc_q;
  assign position_out_o = opos_q;
  assign velocity_out_o = ovel_q;

  `CPJS_ASSERT_NEXT(a_accept_starts, in_valid_i && !in_stall_o, state_q != ST_IDLE,
                    "accepted word did not start the sequencer")
  `CPJS_ASSERT_NEXT(a_out_holds, state_q == ST_OUT && out_valid_q && out_stall_i,
                    state_q == ST_OUT, "result overwrote a stalled word")
  `CPJS_ASSERT_NOW(a_mul_done_waited, mul_done, state_q == ST_WAIT_MUL,
                   "multiplier finished outside a wait step")
  `CPJS_ASSERT_NOW(a_static_zero, state_q == ST_OUT && kind_q == KIND_STATIC,
                   acc_q == 32'sd0, "static link produced nonzero acceleration")

endmodule

// File: tb/tb_cascaded_pd_joint_servo_unit.sv
// ----------------------------------------------------------------------------
// Testbench for cascaded_pd_joint_servo_unit
// A directed table, then randomized servo ticks over many register settings.
// Every result word is checked against an in-bench servo predictor or a typed row,
// with random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_cascaded_pd_joint_servo_unit;
  import cpjs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int      CYCLE_LIMIT = 5000000;
  localparam longint  QPI         = 205887;
  localparam longint  QTWO_PI     = 411775;
  localparam int      IMAX        = 32'sh7fffffff;
  localparam int      IMIN        = 32'sh80000000;

  typedef struct {
    logic signed [31:0] acc;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
  } servo_out_t;

  typedef struct {
    int setup;
    bit op;
    int refv;
    int ff;
    bit typed;
    int e_acc;
    int e_pos;
    int e_vel;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               operation_i = 1'b0;
  logic signed [31:0] reference_i = '0;
  logic signed [31:0] feedforward_velocity_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] acceleration_o;
  logic signed [31:0] position_out_o;
  logic signed [31:0] velocity_out_o;

  cascaded_pd_joint_servo_unit i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state and its copy of the registers.
  link_kind_e kind_q;
  longint min_pos, max_pos, speed_lim, accel_lim, dt_q, inv_dt_q;
  longint joint_pos, joint_vel, last_pos_err, last_vel_err;

  servo_out_t expected_q[$];
  int errors = 0;
  int cycles = 0;

  function automatic longint sat32l(longint v);
    if (v > longint'(IMAX)) return longint'(IMAX);
    if (v < longint'(IMIN)) return longint'(IMIN);
    return v;
  endfunction

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Q16.16 product, rounded toward minus infinity, saturated.
  function automatic longint qmul(longint a, longint b);
    return sat32l((a * b) >>> 16);
  endfunction

  task automatic predict_tick(input bit op, input int refv, input int ff,
                              output servo_out_t r);
    longint acc, vref, err, der, m, a, v, p, k;
    longint kpp, kdp, kpv, kdv;
    bit moving;
    moving = (kind_q == KIND_TRANS) || (kind_q == KIND_ROT);
    kpp = moving ? 131072 : 0;
    kdp = moving ? 13107 : 0;
    kpv = moving ? 327680 : 0;
    kdv = moving ? 32768 : 0;
    acc = 0;
    if (kind_q != KIND_STATIC) begin
      if (op == 1'b0) begin
        err = longint'(refv) - joint_pos;
        if (kind_q == KIND_ROT) begin
          m = (err + QPI) % QTWO_PI;
          if (m < 0) m += QTWO_PI;
          err = m - QPI;
        end else begin
          err = sat32l(err);
        end
        der = qmul(sat32l(err - last_pos_err), inv_dt_q);
        last_pos_err = err;
        vref = sat32l(qmul(err, kpp) + qmul(der, kdp));
        vref = clamp_sym(vref + ff, speed_lim);
      end else begin
        vref = refv;
      end
      err = sat32l(vref - joint_vel);
      der = qmul(sat32l(err - last_vel_err), inv_dt_q);
      last_vel_err = err;
      acc = sat32l(qmul(err, kpv) + qmul(der, kdv));
    end
    if (moving) begin
      a = clamp_sym(acc, accel_lim);
      v = clamp_sym(sat32l(joint_vel + qmul(a, dt_q)), speed_lim);
      p = joint_pos + qmul(v, dt_q);
      joint_vel = v;
      if (kind_q == KIND_ROT) begin
        // Wrap down by whole turns, then up; a narrow range may stay above max.
        if (p > max_pos) begin
          k = (p - max_pos + QTWO_PI - 1) / QTWO_PI;
          p -= k * QTWO_PI;
        end
        if (p < min_pos) begin
          k = (min_pos - p + QTWO_PI - 1) / QTWO_PI;
          p += k * QTWO_PI;
        end
        p = sat32l(p);
      end else begin
        if (p > max_pos) p = max_pos;
        if (p < min_pos) p = min_pos;
      end
      joint_pos = p;
    end
    r.acc = acc[31:0];
    r.pos = joint_pos[31:0];
    r.vel = joint_vel[31:0];
  endtask

  task automatic write_reg(input reg_index_e idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_LINK_KIND: kind_q    = link_kind_e'(val[1:0]);
      REG_MIN_POS:   min_pos   = longint'(signed'(val));
      REG_MAX_POS:   max_pos   = longint'(signed'(val));
      REG_MAX_SPEED: speed_lim = longint'(val[30:0]);
      REG_MAX_ACCEL: accel_lim = longint'(val[30:0]);
      REG_TIME_STEP: dt_q      = longint'(val[16:0]);
      REG_INV_STEP:  inv_dt_q  = longint'(val[30:0]);
      default: ;
    endcase
  endtask

  task automatic write_all(input link_kind_e kind, input int lo, input int hi,
                           input int spd, input int acl, input int dt, input int inv);
    write_reg(REG_LINK_KIND, kind);
    write_reg(REG_MIN_POS, lo);
    write_reg(REG_MAX_POS, hi);
    write_reg(REG_MAX_SPEED, spd);
    write_reg(REG_MAX_ACCEL, acl);
    write_reg(REG_TIME_STEP, dt);
    write_reg(REG_INV_STEP, inv);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // Presents one input word and waits until the unit takes it.
  task automatic send_tick(input bit op, input int refv, input int ff,
                           input bit typed, input servo_out_t typed_res);
    int gap;
    servo_out_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i             <= 1'b1;
    operation_i            <= op;
    reference_i            <= refv;
    feedforward_velocity_i <= ff;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_tick(op, refv, ff, r);
    expected_q.push_back(typed ? typed_res : r);
  endtask

  // Lets every pending result come out before registers change.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic random_setup();
    link_kind_e kind;
    int lo, hi, spd, acl, dt, inv, r;
    r = $urandom_range(0, 9);
    kind = (r < 1) ? KIND_STATIC : (r < 2) ? KIND_BASE : (r < 6) ? KIND_ROT : KIND_TRANS;
    case ($urandom_range(0, 4))
      0: begin lo = IMIN; hi = IMAX; end
      1: begin lo = -205887; hi = 205887; end
      2: begin lo = $urandom_range(0, 65536); hi = lo + $urandom_range(0, 131072); end
      3: begin lo = $urandom_range(65536, 655360); hi = -lo; end
      default: begin lo = -$urandom_range(0, 1310720); hi = $urandom_range(0, 1310720); end
    endcase
    case ($urandom_range(0, 3))
      0: spd = 0;
      1: spd = $urandom();
      default: spd = $urandom_range(1, 20) << 16;
    endcase
    case ($urandom_range(0, 3))
      0: acl = 0;
      1: acl = $urandom();
      default: acl = $urandom_range(1, 500) << 16;
    endcase
    case ($urandom_range(0, 3))
      0: begin dt = 1; inv = IMAX; end
      1: begin dt = 65536; inv = 65536; end
      default: begin
        dt = $urandom_range(65, 6554);
        inv = int'((longint'(65536) * 65536) / dt);
      end
    endcase
    write_all(kind, lo, hi, spd, acl, dt, inv);
  endtask

  task automatic apply_setup(input int setup);
    case (setup)
      1: write_all(KIND_TRANS, -(10 << 16), 10 << 16, 4 << 16, 50 << 16, 655, 6553600);
      2: write_all(KIND_TRANS, 3 << 16, -(3 << 16), 4 << 16, 50 << 16, 655, 6553600);
      3: write_all(KIND_ROT, -205887, 205887, 20 << 16, 500 << 16, 655, 6553600);
      4: write_all(KIND_ROT, 0, 1 << 16, 20 << 16, 500 << 16, 6554, 655360);
      5: write_all(KIND_BASE, -(10 << 16), 10 << 16, 4 << 16, 50 << 16, 655, 6553600);
      6: write_all(KIND_TRANS, IMIN, IMAX, IMAX, IMAX, 65536, 65536);
      default: ;
    endcase
  endtask

  stim_row_t directed[] = '{
    // Static link after reset: zero acceleration, held zero state.
    '{0, 1'b0, IMAX, IMIN, 1'b1, 0, 0, 0},
    '{0, 1'b1, IMIN, IMAX, 1'b1, 0, 0, 0},
    '{0, 1'b0, 0, 0, 1'b1, 0, 0, 0},
    '{1, 1'b0, 5 << 16, 0, 1'b0, 0, 0, 0},
    '{1, 1'b0, 5 << 16, 1 << 16, 1'b0, 0, 0, 0},
    '{1, 1'b1, -(2 << 16), 0, 1'b0, 0, 0, 0},
    '{1, 1'b0, IMAX, IMAX, 1'b0, 0, 0, 0},
    '{1, 1'b0, IMIN, IMIN, 1'b0, 0, 0, 0},
    // Inverted translational range pins the position to min.
    '{2, 1'b0, 1 << 16, 0, 1'b0, 0, 0, 0},
    '{2, 1'b1, 0, 0, 1'b0, 0, 0, 0},
    '{3, 1'b0, 3 << 16, 0, 1'b0, 0, 0, 0},
    '{3, 1'b0, -(3 << 16), 0, 1'b0, 0, 0, 0},
    '{3, 1'b0, IMAX, 0, 1'b0, 0, 0, 0},
    '{3, 1'b1, IMAX, 0, 1'b0, 0, 0, 0},
    '{3, 1'b1, IMIN, 0, 1'b0, 0, 0, 0},
    // Rotational range narrower than one turn.
    '{4, 1'b0, 2 << 16, 0, 1'b0, 0, 0, 0},
    '{4, 1'b1, 5 << 16, 0, 1'b0, 0, 0, 0},
    '{5, 1'b0, 1 << 16, 0, 1'b0, 0, 0, 0},
    '{5, 1'b1, 2 << 16, 0, 1'b0, 0, 0, 0},
    '{6, 1'b0, IMAX, IMAX, 1'b0, 0, 0, 0},
    '{6, 1'b1, IMIN, IMIN, 1'b0, 0, 0, 0},
    '{6, 1'b0, 0, 0, 1'b0, 0, 0, 0}
  };

  int stall_hold = 0;

  always @(posedge clk_i) begin
    servo_out_t e;
    int r;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_cascaded_pd_joint_servo_unit: errors");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word acc=%0d", acceleration_o);
      end else begin
        e = expected_q.pop_front();
        if (acceleration_o !== e.acc || position_out_o !== e.pos ||
            velocity_out_o !== e.vel) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: acc %0d/%0d pos %0d/%0d vel %0d/%0d (exp/got)",
                     e.acc, acceleration_o, e.pos, position_out_o, e.vel, velocity_out_o);
        end
      end
    end
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_stall_i <= 1'b0;
        stall_hold  <= $urandom_range(0, 20);
      end else if (r < 95) begin
        out_stall_i <= 1'b1;
        stall_hold  <= $urandom_range(0, 3);
      end else begin
        out_stall_i <= 1'b1;
        stall_hold  <= $urandom_range(20, 300);
      end
    end
  end

  initial begin
    servo_out_t t;
    int cur_setup, refv, ff;
    bit op;
    kind_q = KIND_STATIC;
    min_pos = 0; max_pos = 0; speed_lim = 0; accel_lim = 0;
    dt_q = 655; inv_dt_q = 6553600;
    joint_pos = 0; joint_vel = 0; last_pos_err = 0; last_vel_err = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_setup = 0;
    foreach (directed[i]) begin
      if (directed[i].setup != cur_setup) begin
        drain();
        cur_setup = directed[i].setup;
        apply_setup(cur_setup);
      end
      t.acc = directed[i].e_acc;
      t.pos = directed[i].e_pos;
      t.vel = directed[i].e_vel;
      send_tick(directed[i].op, directed[i].refv, directed[i].ff, directed[i].typed, t);
    end

    for (int ph = 0; ph < 19; ph++) begin
      drain();
      random_setup();
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(0, 9) < 2) begin
          // Noise: any bit pattern in every field.
          op = $urandom_range(0, 1);
          refv = $urandom();
          ff = $urandom();
        end else begin
          op = ($urandom_range(0, 4) == 0);
          if (op) refv = $signed($urandom_range(0, 20 << 16)) - (10 << 16);
          else refv = int'(joint_pos) + $signed($urandom_range(0, 8 << 16)) - (4 << 16);
          ff = $signed($urandom_range(0, 4 << 16)) - (2 << 16);
        end
        send_tick(op, refv, ff, 1'b0, t);
      end
    end

    drain();
    repeat (400) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_cascaded_pd_joint_servo_unit: clean");
    end else begin
      $display("tb_cascaded_pd_joint_servo_unit: errors");
    end
    $finish;
  end

endmodule

// File: cascaded_pd_joint_servo_unit.f
+incdir+rtl
rtl/cpjs_pkg.sv
rtl/cpjs_mul.sv
rtl/cpjs_mod.sv
rtl/cascaded_pd_joint_servo_unit.sv
tb/tb_cascaded_pd_joint_servo_unit.sv
